FILE: src/battery_gauge_and_charge_detector_top_defines.svh
// Assertion helpers for the RTL; bgcd_ctrl includes them.
`ifndef BATTERY_GAUGE_AND_CHARGE_DETECTOR_TOP_DEFINES_SVH
`define BATTERY_GAUGE_AND_CHARGE_DETECTOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BGCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BGCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/bgcd_pkg.sv
package bgcd_pkg;

    localparam int BGCD_HIST_DEPTH = 4;
    // Must be a power of two; the reading sum is scaled by a shift.
    localparam int SAMPLE_COUNT    = 16;

    localparam int KIND_W  = 2;
    localparam int SUM_W   = 16;
    localparam int TIME_W  = 32;
    localparam int MV_W    = 13;
    localparam int PCT_W   = 7;
    localparam int RAW_W   = 22;
    localparam int AVG_W   = 29;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int THR_W   = 10;

    localparam logic [KIND_W-1:0] KIND_MEASURE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BUSY    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHECK   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd5;

    localparam logic [RAW_W-1:0] RAW_MAX = RAW_W'(8191 * 512);

    localparam int CURVE_PTS = 11;
    localparam int SEG_W     = 4;
    localparam logic [MV_W-1:0] CURVE_MV [CURVE_PTS] = '{
        13'd4150, 13'd4050, 13'd3950, 13'd3850, 13'd3800, 13'd3750,
        13'd3700, 13'd3650, 13'd3600, 13'd3550, 13'd3500};
    localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_PTS] = '{
        7'd100, 7'd95, 7'd85, 7'd70, 7'd60, 7'd50,
        7'd40, 7'd30, 7'd20, 7'd10, 7'd0};

    typedef struct packed {
        logic take;
        logic exec;
        logic avg;
        logic apply;
        logic pct;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic is_measure;
        logic div_done;
    } t_status;

endpackage

FILE: src/bgcd_req_if.sv
interface bgcd_req_if;
    import bgcd_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [SUM_W-1:0]  sample_sum;
    logic              load_busy;
    logic [TIME_W-1:0] now_ms;
    modport source (output valid, kind, sample_sum, load_busy, now_ms, input ready);
    modport sink (input valid, kind, sample_sum, load_busy, now_ms, output ready);
endinterface

FILE: src/bgcd_rsp_if.sv
interface bgcd_rsp_if;
    import bgcd_pkg::*;
    logic             valid;
    logic             ready;
    logic [MV_W-1:0]  smoothed_mv;
    logic [PCT_W-1:0] percent;
    logic             charging;
    modport source (output valid, smoothed_mv, percent, charging, input ready);
    modport sink (input valid, smoothed_mv, percent, charging, output ready);
endinterface

FILE: src/bgcd_ctrl.sv
`include "battery_gauge_and_charge_detector_top_defines.svh"
module bgcd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    input  bgcd_pkg::t_status i_status,
    output bgcd_pkg::t_cmd    o_cmd
);
    import bgcd_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_AVG   = 3'd2;
    localparam logic [2:0] ST_APPLY = 3'd3;
    localparam logic [2:0] ST_PCT   = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       accept;

    assign o_req_ready = (r_state == ST_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    assign o_rsp_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_rsp_ready;
        o_cmd       = '0;
        o_cmd.take  = accept;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = i_status.is_measure ? ST_AVG : ST_PCT;
            end
            ST_AVG: begin
                o_cmd.avg = 1'b1;
                n_state = ST_APPLY;
            end
            ST_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state = ST_PCT;
            end
            ST_PCT: begin
                o_cmd.pct = 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (i_status.div_done) n_state = ST_DONE;
                else o_cmd.div_step = 1'b1;
            end
            ST_DONE: begin
                if (!r_out_valid || i_rsp_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `BGCD_ASSERT_NXT(a_accept_exec, i_clk, i_rst_n, accept, r_state == ST_EXEC)
    `BGCD_ASSERT_NXT(a_done_loads, i_clk, i_rst_n,
        (r_state == ST_DONE) && !r_out_valid, r_out_valid && (r_state == ST_IDLE))
    `BGCD_ASSERT_NXT(a_div_finish, i_clk, i_rst_n,
        (r_state == ST_DIV) && i_status.div_done, r_state == ST_DONE)
    `BGCD_ASSERT_IMP(a_load_only_done, i_clk, i_rst_n, o_cmd.load_out,
        (r_state == ST_DONE) && !o_req_ready)

endmodule

FILE: src/bgcd_dp.sv
module bgcd_dp #(
    parameter int HISTORY_DEPTH = bgcd_pkg::BGCD_HIST_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bgcd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bgcd_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [bgcd_pkg::KIND_W-1:0]     i_kind,
    input  logic [bgcd_pkg::SUM_W-1:0]      i_sample_sum,
    input  logic                            i_load_busy,
    input  logic [bgcd_pkg::TIME_W-1:0]     i_now_ms,
    input  bgcd_pkg::t_cmd                  i_cmd,
    output bgcd_pkg::t_status               o_status,
    output logic [bgcd_pkg::MV_W-1:0]       o_smoothed_mv,
    output logic [bgcd_pkg::PCT_W-1:0]      o_percent,
    output logic                            o_charging
);
    import bgcd_pkg::*;

    localparam int FILL_W    = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_SHIFT = 4 + $clog2(SAMPLE_COUNT);
    localparam int MPROD_W   = SUM_W + CFG_W;
    localparam int WPROD_W   = AVG_W + CFG_W;
    localparam int DIFF_W    = 23;
    localparam int PPROD_W   = DIFF_W + 4;
    localparam int Q_W       = PPROD_W - 16;

    // configuration
    logic [CFG_W-1:0] r_gain, r_weight, r_settle, r_holdoff, r_interval;
    logic [THR_W-1:0] r_thresh;

    // latched request
    logic [KIND_W-1:0] r_kind;
    logic [SUM_W-1:0]  r_sum;
    logic              r_busy;
    logic [TIME_W-1:0] r_now;

    // gauge state
    logic [AVG_W-1:0]   r_avg;
    logic               r_loaded;
    logic [RAW_W-1:0]   r_raw;
    logic [MPROD_W-1:0] r_mprod;
    logic [WPROD_W-1:0] r_wprod;
    logic               r_up, r_apply;

    // detector state
    logic               r_fcs;
    logic [TIME_W-1:0]  r_fct, r_htime, r_bend;
    logic [RAW_W-1:0]   r_hist [HISTORY_DEPTH];
    logic [FILL_W-1:0]  r_fill;
    logic               r_flag, r_known, r_load, r_ans;

    // percent
    logic [Q_W-1:0]   r_rem;
    logic [6:0]       r_div;
    logic [3:0]       r_q;
    logic [PCT_W-1:0] r_plo;

    assign o_status.is_measure = (r_kind == KIND_MEASURE);
    assign o_status.div_done   = (r_rem < Q_W'(r_div));

    // measure path
    logic [MPROD_W-SUM_SHIFT-1:0] raw_full;
    logic [RAW_W-1:0]             raw_sat;
    logic [AVG_W-1:0]             v_new, avg_diff;
    always_comb begin
        raw_full = r_mprod[MPROD_W-1:SUM_SHIFT];
        raw_sat  = (raw_full > (MPROD_W-SUM_SHIFT)'(RAW_MAX)) ? RAW_MAX
                                                               : RAW_W'(raw_full);
        v_new    = {raw_sat, 7'd0};
        avg_diff = (v_new >= r_avg) ? (v_new - r_avg) : (r_avg - v_new);
    end

    // check path
    logic              fresh, sample, settling, holdoff, full, n_flag;
    logic [TIME_W-1:0] fct_eff, since_busy;
    logic [FILL_W-1:0] fill_eff;
    logic [RAW_W-1:0]  newest, oldest;
    logic [RAW_W-1:0]  thr;
    always_comb begin
        fresh      = !r_fcs;
        fct_eff    = fresh ? r_now : r_fct;
        settling   = (r_now - fct_eff) < TIME_W'(r_settle);
        since_busy = r_now - r_bend;
        holdoff    = r_load || since_busy[TIME_W-1];
        sample     = fresh || ((r_now - r_htime) >= TIME_W'(r_interval));
        fill_eff   = (sample && (r_fill < FILL_W'(HISTORY_DEPTH))) ? r_fill + 1'b1 : r_fill;
        full       = (fill_eff == FILL_W'(HISTORY_DEPTH));
        newest     = sample ? r_raw : r_hist[0];
        oldest     = sample ? r_hist[HISTORY_DEPTH-2] : r_hist[HISTORY_DEPTH-1];
        thr        = {3'd0, r_thresh, 9'd0};
        n_flag     = r_flag;
        if (full && (newest > oldest) && ((newest - oldest) > thr)) n_flag = 1'b1;
        else if (full && (oldest > newest) && ((oldest - newest) > thr)) n_flag = 1'b0;
        else if (!r_known) n_flag = 1'b0;
    end

    // curve segment lookup
    logic               hi_sat, lo_sat;
    logic [SEG_W-1:0]   seg, seg_hi;
    logic [DIFF_W-1:0]  pdiff;
    logic [3:0]         dp;
    logic [PPROD_W-1:0] pprod;
    always_comb begin
        hi_sat = r_avg >= {CURVE_MV[0], 16'd0};
        lo_sat = r_avg <= {CURVE_MV[CURVE_PTS-1], 16'd0};
        seg    = SEG_W'(1);
        for (int i = CURVE_PTS - 1; i >= 1; i--) begin
            if (r_avg >= {CURVE_MV[i], 16'd0}) seg = SEG_W'(i);
        end
        seg_hi = seg - 1'b1;
        pdiff  = DIFF_W'(r_avg - {CURVE_MV[seg], 16'd0});
        dp     = 4'(CURVE_PCT[seg_hi] - CURVE_PCT[seg]);
        pprod  = pdiff * dp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= CFG_W'(16384);
            r_weight   <= CFG_W'(1311);
            r_thresh   <= THR_W'(20);
            r_settle   <= CFG_W'(5000);
            r_holdoff  <= CFG_W'(2500);
            r_interval <= CFG_W'(1000);
            r_avg      <= '0;
            r_loaded   <= 1'b0;
            r_raw      <= '0;
            r_fcs      <= 1'b0;
            r_fct      <= '0;
            r_fill     <= '0;
            r_htime    <= '0;
            r_flag     <= 1'b0;
            r_known    <= 1'b0;
            r_load     <= 1'b0;
            r_bend     <= '0;
            r_apply    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_GAIN:     r_gain     <= i_cfg_data;
                    REG_WEIGHT:   r_weight   <= i_cfg_data;
                    REG_THRESH:   r_thresh   <= i_cfg_data[THR_W-1:0];
                    REG_SETTLE:   r_settle   <= i_cfg_data;
                    REG_HOLDOFF:  r_holdoff  <= i_cfg_data;
                    REG_INTERVAL: r_interval <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.exec && (r_kind == KIND_BUSY)) begin
                r_load <= r_busy;
                if (r_busy) r_bend <= r_now + TIME_W'(r_holdoff);
            end
            if (i_cmd.exec && (r_kind == KIND_CHECK) && (r_raw != '0)) begin
                r_fcs <= 1'b1;
                r_fct <= fct_eff;
                if (settling || holdoff) begin
                    r_fill  <= '0;
                    r_htime <= r_now;
                end else begin
                    if (sample) r_htime <= r_now;
                    r_fill <= fill_eff;
                    r_flag <= n_flag;
                    if (full && (n_flag != r_flag || r_known ||
                        ((newest > oldest) && ((newest - oldest) > thr)) ||
                        ((oldest > newest) && ((oldest - newest) > thr))))
                        r_known <= r_known ||
                            ((newest > oldest) && ((newest - oldest) > thr)) ||
                            ((oldest > newest) && ((oldest - newest) > thr));
                end
            end
            if (i_cmd.avg) begin
                r_raw <= raw_sat;
                if (!r_loaded) begin
                    r_avg    <= v_new;
                    r_loaded <= 1'b1;
                    r_apply  <= 1'b0;
                end else begin
                    r_apply <= 1'b1;
                end
            end
            if (i_cmd.apply && r_apply) begin
                if (r_up) r_avg <= r_avg + AVG_W'(r_wprod >> 16);
                else      r_avg <= r_avg - AVG_W'(r_wprod >> 16);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_kind <= i_kind;
            r_sum  <= i_sample_sum;
            r_busy <= i_load_busy;
            r_now  <= i_now_ms;
        end
        if (i_cmd.exec) begin
            r_mprod <= r_sum * r_gain;
            unique case (r_kind)
                KIND_CHECK: begin
                    if (r_raw == '0) r_ans <= 1'b0;
                    else if (settling) r_ans <= 1'b0;
                    else if (holdoff) r_ans <= r_flag;
                    else r_ans <= n_flag;
                end
                default: r_ans <= r_flag;
            endcase
        end
        if (i_cmd.exec && (r_kind == KIND_CHECK) && (r_raw != '0) && !settling
            && !holdoff && sample) begin
            for (int i = HISTORY_DEPTH - 1; i > 0; i--) r_hist[i] <= r_hist[i-1];
            r_hist[0] <= r_raw;
        end
        if (i_cmd.avg) begin
            r_wprod <= avg_diff * r_weight;
            r_up    <= (v_new >= r_avg);
        end
        if (i_cmd.pct) begin
            r_q   <= '0;
            r_div <= 7'(CURVE_MV[seg_hi] - CURVE_MV[seg]);
            if (hi_sat) begin
                r_plo <= CURVE_PCT[0];
                r_rem <= '0;
            end else if (lo_sat) begin
                r_plo <= CURVE_PCT[CURVE_PTS-1];
                r_rem <= '0;
            end else begin
                r_plo <= CURVE_PCT[seg];
                r_rem <= pprod[PPROD_W-1:16];
            end
        end
        if (i_cmd.div_step) begin
            r_rem <= r_rem - Q_W'(r_div);
            r_q   <= r_q + 1'b1;
        end
        if (i_cmd.load_out) begin
            o_smoothed_mv <= r_avg[AVG_W-1:16];
            o_percent     <= r_plo + PCT_W'(r_q);
            o_charging    <= r_ans;
        end
    end

endmodule

FILE: src/battery_gauge_and_charge_detector_top.sv
// Battery gauge and charge detector.
// Requests arrive on i_req (valid/ready): kind 0 measures a sum of readings,
// kind 1 updates the load-busy flag, kind 2 runs the charging check, kind 3
// only reports. Every request yields one response on o_rsp: smoothed mV,
// charge percent from the eleven-point curve, and the charging bit.
// Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data; the user
// must write them only while idle, which the block does not enforce.
// A request passes EXEC, then AVG and APPLY for a measure only, then PCT,
// DIV and DONE; in DIV the percent quotient is found by repeated
// subtraction of the segment span, and DONE loads the response register.
// One request is in work at a time; i_req.ready is
// high whenever the sequencer is idle, also while a response still waits.
// A stalled o_rsp holds its response; a finished request then waits in the
// sequencer until the response register frees.
// Reset (synchronous, active low) restores register defaults and clears the
// average, flags, timers and history fill; history entries are not cleared.
module battery_gauge_and_charge_detector_top #(
    parameter int HISTORY_DEPTH = bgcd_pkg::BGCD_HIST_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bgcd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bgcd_pkg::CFG_W-1:0]     i_cfg_data,
    bgcd_req_if.sink                       i_req,
    bgcd_rsp_if.source                     o_rsp
);
    import bgcd_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer: one request at a time, output handshake owned here
    bgcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // gauge, detector and curve arithmetic
    bgcd_dp #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_kind        (i_req.kind),
        .i_sample_sum  (i_req.sample_sum),
        .i_load_busy   (i_req.load_busy),
        .i_now_ms      (i_req.now_ms),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_smoothed_mv (o_rsp.smoothed_mv),
        .o_percent     (o_rsp.percent),
        .o_charging    (o_rsp.charging)
    );

endmodule
